// ----- src/humidity_temp_frame_decoder_top_macros.svh -----
// Assertion helpers shared by the decoder RTL.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge, off while reset is asserted.
`define HTFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("htfd assertion failed");
// Same check, held during reset as well.
`define HTFD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("htfd assertion failed");
`else
`define HTFD_ASSERT(lbl, clk, rst_n, prop)
`define HTFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- src/htfd_pkg.sv -----
`timescale 1ns / 1ps

package htfd_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  // Byte position inside a frame; anything from IdxIdle up waits for a start.
  localparam logic [2:0] IdxTempHi  = 3'd0;
  localparam logic [2:0] IdxTempLo  = 3'd1;
  localparam logic [2:0] IdxTempCrc = 3'd2;
  localparam logic [2:0] IdxHumHi   = 3'd3;
  localparam logic [2:0] IdxHumLo   = 3'd4;
  localparam logic [2:0] IdxHumCrc  = 3'd5;
  localparam logic [2:0] IdxIdle    = 3'd6;

  localparam int FullScale  = 65535;
  localparam int TempGain   = 1750;
  localparam int TempOffset = 450 * FullScale;
  localparam int HumGain    = 125;
  localparam int HumOffset  = 6 * FullScale;
  localparam int HumMax     = 100 * FullScale;

  localparam int MagW  = 27;  // 1750 * 65535 fits in 27 bits
  localparam int HMagW = 23;  // 125 * 65535 fits in 23 bits
  localparam int QuoW  = MagW - 16;

  localparam logic [6:0] HumFull = 7'd100;

  typedef struct packed {
    logic        bad;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } frame_t;

  typedef struct packed {
    logic             bad;
    logic             t_neg;
    logic [MagW-1:0]  t_mag;
    logic             h_zero;
    logic             h_full;
    logic [HMagW-1:0] h_mag;
  } conv_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // x / 65535 for x < 2^27: x = q0*65536 + lo = q0*65535 + (q0 + lo), and
  // q0 + lo stays below twice the divisor, so one correction step is enough.
  function automatic logic [QuoW-1:0] div_full_scale(input logic [MagW-1:0] x);
    logic [QuoW-1:0] q0;
    logic [16:0]     r0;
    q0 = x[MagW-1:16];
    r0 = {1'b0, x[15:0]} + 17'(q0);
    return (r0 >= 17'(FullScale)) ? q0 + QuoW'(1) : q0;
  endfunction

endpackage

// ----- src/htfd_in_if.sv -----
`timescale 1ns / 1ps

interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ----- src/htfd_out_if.sv -----
`timescale 1ns / 1ps

interface htfd_out_if;
  logic              valid;
  logic              ready;
  logic              status;
  logic signed [11:0] temp_tenths;
  logic [6:0]        humidity_pct;

  modport source (output valid, output status, output temp_tenths, output humidity_pct,
                  input ready);
  modport sink (input valid, input status, input temp_tenths, input humidity_pct,
                output ready);
endinterface

// ----- src/htfd_frame.sv -----
`timescale 1ns / 1ps
`include "humidity_temp_frame_decoder_top_macros.svh"

module htfd_frame (
  input  logic            clk_i,
  input  logic            rst_ni,
  htfd_in_if.sink         rx_i,
  output logic            frm_valid_o,
  input  logic            frm_ready_i,
  output htfd_pkg::frame_t frm_o
);
  import htfd_pkg::*;

  logic [2:0]  idx_q, idx_d, idx_cur;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] traw_q, traw_d;
  logic [15:0] hraw_q, hraw_d;
  logic        bad_q, bad_d, bad_cur;
  logic        frm_valid_q, frm_valid_d;
  frame_t      frm_q, frm_d;
  logic        accept;
  logic        emit;

  assign rx_i.ready = !frm_valid_q || frm_ready_i;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    idx_cur = rx_i.frame_start ? IdxTempHi : idx_q;
    bad_cur = rx_i.frame_start ? 1'b0 : bad_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    traw_d  = traw_q;
    hraw_d  = hraw_q;
    bad_d   = bad_q;
    emit    = 1'b0;
    frm_d   = frm_q;
    if (accept) begin
      bad_d = bad_cur;
      idx_d = (idx_cur >= IdxIdle) ? idx_cur : idx_cur + 3'd1;
      unique case (idx_cur)
        IdxTempHi: begin
          crc_d  = crc_byte(CrcInit, rx_i.rx_byte);
          traw_d = {rx_i.rx_byte, 8'h00};
        end
        IdxTempLo: begin
          crc_d  = crc_byte(crc_q, rx_i.rx_byte);
          traw_d = {traw_q[15:8], rx_i.rx_byte};
        end
        IdxTempCrc: begin
          bad_d = (crc_q != rx_i.rx_byte);
        end
        IdxHumHi: begin
          crc_d  = crc_byte(CrcInit, rx_i.rx_byte);
          hraw_d = {rx_i.rx_byte, 8'h00};
        end
        IdxHumLo: begin
          crc_d  = crc_byte(crc_q, rx_i.rx_byte);
          hraw_d = {hraw_q[15:8], rx_i.rx_byte};
        end
        IdxHumCrc: begin
          emit           = 1'b1;
          idx_d          = IdxIdle;
          frm_d.bad      = bad_cur || (crc_q != rx_i.rx_byte);
          frm_d.temp_raw = traw_q;
          frm_d.hum_raw  = hraw_q;
        end
        default: begin
          idx_d = idx_q;
        end
      endcase
    end
    frm_valid_d = emit ? 1'b1 : (frm_ready_i ? 1'b0 : frm_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IdxIdle;
      crc_q       <= CrcInit;
      traw_q      <= '0;
      hraw_q      <= '0;
      bad_q       <= 1'b0;
      frm_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      traw_q      <= traw_d;
      hraw_q      <= hraw_d;
      bad_q       <= bad_d;
      frm_valid_q <= frm_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frm_q <= frm_d;
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

  `HTFD_ASSERT(a_start_restarts, clk_i, rst_ni,
               (accept && rx_i.frame_start) |=> (idx_q == IdxTempLo))
  `HTFD_ASSERT(a_frame_held, clk_i, rst_ni,
               (frm_valid_q && !frm_ready_i) |=> (frm_valid_q && $stable(frm_q)))
endmodule

// ----- src/htfd_conv.sv -----
`timescale 1ns / 1ps
`include "humidity_temp_frame_decoder_top_macros.svh"

module htfd_conv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frm_valid_i,
  output logic             frm_ready_o,
  input  htfd_pkg::frame_t frm_i,
  htfd_out_if.source       res_o
);
  import htfd_pkg::*;

  // Stage A: scale and offset, take magnitudes.
  logic            a_valid_q, a_ready;
  conv_t           a_q, a_d;
  logic [MagW-1:0] t_prod;
  logic [HMagW-1:0] h_prod;

  // Stage B: divide by full scale, apply sign, clamp and error zeroing.
  logic               o_valid_q, o_ready;
  logic               o_status_q, o_status_d;
  logic signed [11:0] o_temp_q, o_temp_d;
  logic [6:0]         o_hum_q, o_hum_d;
  logic [QuoW-1:0]    t_quo, h_quo;
  logic [11:0]        t_quo_ext;

  assign o_ready     = !o_valid_q || res_o.ready;
  assign a_ready     = !a_valid_q || o_ready;
  assign frm_ready_o = a_ready;

  always_comb begin
    t_prod   = MagW'(frm_i.temp_raw) * MagW'(TempGain);
    h_prod   = HMagW'(frm_i.hum_raw) * HMagW'(HumGain);
    a_d.bad  = frm_i.bad;
    a_d.t_neg = t_prod < MagW'(TempOffset);
    a_d.t_mag = a_d.t_neg ? MagW'(TempOffset) - t_prod : t_prod - MagW'(TempOffset);
    a_d.h_zero = h_prod < HMagW'(HumOffset);
    a_d.h_mag  = h_prod - HMagW'(HumOffset);
    a_d.h_full = !a_d.h_zero && (a_d.h_mag > HMagW'(HumMax));
  end

  always_comb begin
    t_quo     = div_full_scale(a_q.t_mag);
    h_quo     = div_full_scale(MagW'(a_q.h_mag));
    t_quo_ext = 12'(t_quo);
    o_status_d = a_q.bad;
    if (a_q.bad) begin
      o_temp_d = '0;
      o_hum_d  = '0;
    end else begin
      o_temp_d = a_q.t_neg ? $signed(-t_quo_ext) : $signed(t_quo_ext);
      priority if (a_q.h_zero) begin
        o_hum_d = '0;
      end else if (a_q.h_full) begin
        o_hum_d = HumFull;
      end else begin
        o_hum_d = h_quo[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= frm_valid_i;
      end
      if (o_ready) begin
        o_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && frm_valid_i) begin
      a_q <= a_d;
    end
    if (o_ready && a_valid_q) begin
      o_status_q <= o_status_d;
      o_temp_q   <= o_temp_d;
      o_hum_q    <= o_hum_d;
    end
  end

  assign res_o.valid        = o_valid_q;
  assign res_o.status       = o_status_q;
  assign res_o.temp_tenths  = o_temp_q;
  assign res_o.humidity_pct = o_hum_q;

  `HTFD_ASSERT(a_stage_moves, clk_i, rst_ni, (a_valid_q && o_ready) |=> o_valid_q)
  `HTFD_ASSERT(a_error_zeroes, clk_i, rst_ni,
               (o_valid_q && o_status_q) |-> (o_temp_q == 12'sd0 && o_hum_q == 7'd0))
  `HTFD_ASSERT(a_hum_range, clk_i, rst_ni, o_valid_q |-> (o_hum_q <= HumFull))
  `HTFD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> (!o_valid_q && !a_valid_q))
endmodule

// ----- src/humidity_temp_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// rx_i     in   valid / ready  rx_byte[7:0], frame_start
// res_o    out  valid / ready  status, temp_tenths[11:0] signed, humidity_pct[6:0]
//
// One byte per cycle while rx_i.ready is high; the CRC is a byte-wide step in the frame tracker.
// After the sixth byte is taken, a result passes the frame, scale and divide registers in turn.
// rst_ni (async, active low) puts the tracker idle until a frame_start byte.
// res_o stalls back up stage by stage; rx_i.ready drops only when the frame
// register is full and cannot move on.

module humidity_temp_frame_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  htfd_in_if.sink    rx_i,
  htfd_out_if.source res_o
);
  import htfd_pkg::*;

  logic   frm_valid;
  logic   frm_ready;
  frame_t frm;

  htfd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .frm_valid_o (frm_valid),
    .frm_ready_i (frm_ready),
    .frm_o       (frm)
  );

  htfd_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (frm_valid),
    .frm_ready_o (frm_ready),
    .frm_i       (frm),
    .res_o       (res_o)
  );
endmodule

// ----- bench/tb_humidity_temp_frame_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder_top;
  import htfd_pkg::*;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusCrcErr = 1'b1;

  localparam logic [7:0] CrcSeed = 8'hFF;
  localparam logic [7:0] CrcGen  = 8'h31;

  localparam longint RawSpan   = 65535;
  localparam longint TempSpan  = 1750;
  localparam longint TempFloor = -450;
  localparam longint HumSpan   = 125;
  localparam longint HumFloor  = -6;
  localparam longint HumCeil   = 100;

  localparam int ByteTarget = 750;
  localparam int CycleLimit = 400000;
  localparam int HoldOffLen = 300;

  typedef struct packed {
    logic               status;
    logic signed [11:0] temp_tenths;
    logic [6:0]         humidity_pct;
  } reading_t;

  class reading_scoreboard;
    logic [2:0]  pos;
    logic [7:0]  crc;
    logic [15:0] t_raw;
    logic [15:0] h_raw;
    logic        t_crc_bad;
    reading_t    expected_readings[$];
    int unsigned mismatches;

    function new();
      pos        = IdxIdle;
      crc        = CrcSeed;
      t_raw      = '0;
      h_raw      = '0;
      t_crc_bad  = 1'b0;
      mismatches = 0;
    endfunction

    // bit-serial form, MSB first
    function logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] b);
      logic [7:0] c;
      c = acc;
      for (int i = 7; i >= 0; i--) begin
        c = {c[6:0], 1'b0} ^ ((c[7] ^ b[i]) ? CrcGen : 8'h00);
      end
      return c;
    endfunction

    function logic signed [11:0] tenths_of(logic [15:0] raw);
      longint num;
      num = TempFloor * RawSpan + TempSpan * longint'(raw);
      return 12'(num / RawSpan);  // truncates toward zero
    endfunction

    function logic [6:0] percent_of(logic [15:0] raw);
      longint num;
      num = HumFloor * RawSpan + HumSpan * longint'(raw);
      if (num < 0) return 7'd0;
      if (num > HumCeil * RawSpan) return 7'(HumCeil);
      return 7'(num / RawSpan);
    endfunction

    // Returns 1 when the byte is part of a frame, 0 when it is ignored.
    function bit take_byte(logic [7:0] b, logic fs);
      reading_t r;
      if (fs) begin
        pos       = IdxTempHi;
        t_crc_bad = 1'b0;
      end
      if (pos >= IdxIdle) return 1'b0;
      if (pos == IdxHumCrc) begin
        if (t_crc_bad || crc != b) begin
          r = '{status: StatusCrcErr, temp_tenths: '0, humidity_pct: '0};
        end else begin
          r = '{status: StatusOk, temp_tenths: tenths_of(t_raw),
                humidity_pct: percent_of(h_raw)};
        end
        expected_readings.push_back(r);
        pos = IdxIdle;
      end else begin
        case (pos)
          IdxTempHi: begin
            crc   = crc8_step(CrcSeed, b);
            t_raw = {b, 8'h00};
          end
          IdxTempLo: begin
            crc        = crc8_step(crc, b);
            t_raw[7:0] = b;
          end
          IdxTempCrc: t_crc_bad = (crc != b);
          IdxHumHi: begin
            crc   = crc8_step(CrcSeed, b);
            h_raw = {b, 8'h00};
          end
          IdxHumLo: begin
            crc        = crc8_step(crc, b);
            h_raw[7:0] = b;
          end
          default: ;
        endcase
        pos = pos + 3'd1;
      end
      return 1'b1;
    endfunction

    function void check_reading(logic status, logic signed [11:0] temp, logic [6:0] hum);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $error("reading with none pending: status %0d temp_tenths %0d humidity_pct %0d",
               status, temp, hum);
        mismatches++;
        return;
      end
      want = expected_readings.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (temp !== want.temp_tenths) begin
        $error("temp_tenths: expected %0d, actual %0d", want.temp_tenths, temp);
        mismatches++;
      end
      if (hum !== want.humidity_pct) begin
        $error("humidity_pct: expected %0d, actual %0d", want.humidity_pct, hum);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  htfd_in_if  rx_if ();
  htfd_out_if res_if ();

  reading_scoreboard sb = new();

  int bytes_taken   = 0;
  int bytes_sent    = 0;
  int readings_seen = 0;
  int send_idle_pct = 0;
  int cycle_count;

  humidity_temp_frame_decoder_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always #1 clk_i = ~clk_i;

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int mode_left;
    int idle_pct;
    bit held_off;
    stall_left = 0;
    mode_left  = 0;
    idle_pct   = 0;
    held_off   = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        sb.check_reading(res_if.status, res_if.temp_tenths, res_if.humidity_pct);
        readings_seen++;
      end
      if (mode_left == 0) begin
        mode_left = 128;
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 20;
          default: idle_pct = 50;
        endcase
      end
      mode_left--;
      // one long hold-off so the pipeline fills and backs up into rx
      if (!held_off && readings_seen >= 25) begin
        held_off   = 1'b1;
        stall_left = HoldOffLen;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      rx_if.valid       <= 1'b0;
      rx_if.rx_byte     <= 8'($urandom);
      rx_if.frame_start <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid       <= 1'b1;
    rx_if.rx_byte     <= b;
    rx_if.frame_start <= fs;
    do @(posedge clk_i); while (!rx_if.ready);
    if (sb.take_byte(b, fs)) bytes_taken++;
    bytes_sent++;
    if (bytes_sent % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 20;
        default: send_idle_pct = 60;
      endcase
    end
  endtask

  // corrupt[0] spoils the temperature CRC, corrupt[1] the humidity CRC
  task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                            input int n_bytes, input logic [1:0] corrupt);
    logic [7:0] fb [6];
    fb[0] = t_word[15:8];
    fb[1] = t_word[7:0];
    fb[2] = sb.crc8_step(sb.crc8_step(CrcSeed, fb[0]), fb[1]);
    fb[3] = h_word[15:8];
    fb[4] = h_word[7:0];
    fb[5] = sb.crc8_step(sb.crc8_step(CrcSeed, fb[3]), fb[4]);
    if (corrupt[0]) fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
    if (corrupt[1]) fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < n_bytes; i++) begin
      send_byte(fb[i], i == 0);
    end
  endtask

  // mostly uniform, sometimes a clamp or full-scale edge
  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 9) != 0) return 16'($urandom);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd3145;
      3: return 16'd3146;
      4: return 16'd55573;
      default: return 16'd55574;
    endcase
  endfunction

  initial begin : stimulus
    int pick;
    int n_noise;
    rst_ni            <= 1'b0;
    rx_if.valid       <= 1'b0;
    rx_if.rx_byte     <= 8'h00;
    rx_if.frame_start <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, dropped partial frame, restart on the sixth byte,
    // a temperature CRC error, then bytes while idle
    send_frame(16'h0000, 16'h0000, 6, 2'b00);
    send_frame(16'hFFFF, 16'hFFFF, 6, 2'b00);
    send_frame(16'h0001, 16'd3145, 2, 2'b00);
    send_frame(16'h0001, 16'd55574, 5, 2'b00);
    send_frame(16'h8000, 16'd3146, 6, 2'b01);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);

    while (bytes_taken < ByteTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(pick_word(), pick_word(), 6, 2'b00);
      end else if (pick < 80) begin
        send_frame(pick_word(), pick_word(), 6, 2'($urandom_range(1, 3)));
      end else if (pick < 88) begin
        send_frame(pick_word(), pick_word(), $urandom_range(1, 5), 2'b00);
      end else begin
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end
    end
    rx_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
